/* hw/rtl/khm_pkg.sv */
// ----------------------------------------------------------------------------
// khm_pkg
// Shared widths, defaults and command/status codes for the k-way heap merge.
// ----------------------------------------------------------------------------
package khm_pkg;

  localparam int LISTS_DEF      = 8;
  localparam int LIST_DEPTH_DEF = 16;

  localparam int CMD_W    = 2;
  localparam int IDX_W    = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;

  // request commands
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BEGIN = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POP   = 2'd2;

  // result status
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_PHASE = 2'd3;

endpackage

/* hw/rtl/khm_if.sv */
// ----------------------------------------------------------------------------
// khm_if
// Valid/ready channels for merge requests and merge results.
// ----------------------------------------------------------------------------
interface khm_in_if;
  logic                              valid;
  logic                              ready;
  logic        [khm_pkg::CMD_W-1:0]   command;
  logic        [khm_pkg::IDX_W-1:0]   list_index;
  logic signed [khm_pkg::VALUE_W-1:0] value;

  modport source (output valid, command, list_index, value, input ready);
  modport sink   (input valid, command, list_index, value, output ready);
endinterface

interface khm_out_if;
  logic                               valid;
  logic                               ready;
  logic        [khm_pkg::STATUS_W-1:0] status;
  logic signed [khm_pkg::VALUE_W-1:0]  out_value;
  logic        [khm_pkg::IDX_W-1:0]    out_list;
  logic                               merge_done;

  modport source (output valid, status, out_value, out_list, merge_done, input ready);
  modport sink   (input valid, status, out_value, out_list, merge_done, output ready);
endinterface

/* hw/rtl/k_way_heap_merge.sv */
// ----------------------------------------------------------------------------
// k_way_heap_merge - load appends to a list; pop takes the heap top, sifts the last entry
// down and refills from the popped list with a sift-up; begin fills the heap from every list.
// One request at a time on one heap RAM port and comparator; an untaken result stalls it.
// Reset (sync, rst_n low): lists and heap empty, loading phase; no clearing pass.
// ----------------------------------------------------------------------------
module k_way_heap_merge #(
  parameter int LISTS      = khm_pkg::LISTS_DEF,
  parameter int LIST_DEPTH = khm_pkg::LIST_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  khm_in_if.sink       in_chan,
  khm_out_if.source    out_chan
);

  localparam int VW     = khm_pkg::VALUE_W;
  localparam int LW     = $clog2(LISTS);            // list / heap slot index
  localparam int CW     = $clog2(LIST_DEPTH + 1);   // head / fill counters
  localparam int CNTW   = $clog2(LISTS + 1);        // heap occupancy
  localparam int SDEPTH = LISTS * LIST_DEPTH;
  localparam int SAW    = $clog2(SDEPTH);
  localparam int EW     = VW + LW;                  // heap entry {value, source}
  localparam int MW     = 2 * CW;                   // list meta {head, fill}

  // Sequencer. Every heap step is one RAM read followed by one compare.
  typedef enum logic [16:0] {
    S_IDLE     = 17'h00001,
    S_LD_RD    = 17'h00002,
    S_LD_CHK   = 17'h00004,
    S_RF_RD    = 17'h00008,
    S_RF_CHK   = 17'h00010,
    S_RF_VAL   = 17'h00020,
    S_UP_CHK   = 17'h00040,
    S_UP_CMP   = 17'h00080,
    S_RF_NEXT  = 17'h00100,
    S_POP_RD   = 17'h00200,
    S_POP_TOP  = 17'h00400,
    S_POP_LAST = 17'h00800,
    S_DN_L     = 17'h01000,
    S_DN_LC    = 17'h02000,
    S_DN_RC    = 17'h04000,
    S_DN_MV    = 17'h08000,
    S_DONE     = 17'h10000
  } state_t;

  state_t state_r, state_nxt;

  // control state
  logic [CNTW-1:0]  count_r, count_nxt;     // heap occupancy
  logic             merging_r, merging_nxt; // merge phase
  logic [LISTS-1:0] lvalid_r, lvalid_nxt;   // list meta written since last clear
  logic             out_valid_r;

  // working registers
  logic        [LW-1:0] lst_r, lst_nxt;     // current list
  logic signed [VW-1:0] val_r, val_nxt;     // value being loaded
  logic                 ctx_pop_r, ctx_pop_nxt;
  logic        [LW-1:0] pos_r, pos_nxt;     // heap hole position
  logic        [LW-1:0] bpos_r, bpos_nxt;   // best child position
  logic        [EW-1:0] cur_r, cur_nxt;     // entry being sifted
  logic        [EW-1:0] best_r, best_nxt;   // smallest of hole and children

  // result being assembled
  logic [khm_pkg::STATUS_W-1:0] res_status_r, res_status_nxt;
  logic signed [VW-1:0]         res_value_r, res_value_nxt;
  logic [khm_pkg::IDX_W-1:0]    res_list_r, res_list_nxt;

  // output register
  logic [khm_pkg::STATUS_W-1:0] out_status_r;
  logic signed [VW-1:0]         out_value_r;
  logic [khm_pkg::IDX_W-1:0]    out_list_r;
  logic                         out_done_r;
  logic                         out_load;

  // memories
  logic          meta_we;
  logic [MW-1:0] meta_wdata, meta_rdata;
  logic           store_we;
  logic [SAW-1:0] store_base, store_raddr, store_waddr;
  logic [VW-1:0]  store_rdata;
  logic          heap_we;
  logic [LW-1:0] heap_raddr;
  logic [EW-1:0] heap_wdata, heap_rdata;

  // derived
  logic [CW-1:0]        m_head, m_fill;
  logic signed [VW-1:0] hr_value;
  logic [LW-1:0]        hr_src;
  logic [LW:0]          l_w, r_w, cnt_ext;
  logic [LW-1:0]        par_w;
  logic [CNTW-1:0]      cnt_dec;
  logic [EW-1:0]        cmp_a, cmp_b;
  logic                 cmp_less;

  // List meta reads as zero until written in the current merge round
  assign m_head = lvalid_r[lst_r] ? meta_rdata[MW-1:CW] : '0;
  assign m_fill = lvalid_r[lst_r] ? meta_rdata[CW-1:0]  : '0;

  assign store_base  = SAW'(lst_r) * SAW'(LIST_DEPTH);
  assign store_raddr = store_base + SAW'(m_head);
  assign store_waddr = store_base + SAW'(m_fill);

  assign hr_value = signed'(heap_rdata[EW-1:LW]);
  assign hr_src   = heap_rdata[LW-1:0];

  // children and parent of the hole
  assign l_w     = {pos_r, 1'b1};
  assign r_w     = l_w + (LW+1)'(1);
  assign cnt_ext = (LW+1)'(count_r);
  assign par_w   = (pos_r - LW'(1)) >> 1;
  assign cnt_dec = count_r - CNTW'(1);

  // Shared comparator: sift-up tests hole entry against parent,
  // sift-down tests each child against the best so far.
  assign cmp_a = (state_r == S_UP_CMP) ? cur_r : heap_rdata;
  assign cmp_b = (state_r == S_UP_CMP) ? heap_rdata :
                 (state_r == S_DN_RC)  ? best_r     : cur_r;

  khm_cmp #(
    .SRC_W (LW)
  ) u_cmp (
    .a_value (signed'(cmp_a[EW-1:LW])),
    .a_src   (cmp_a[LW-1:0]),
    .b_value (signed'(cmp_b[EW-1:LW])),
    .b_src   (cmp_b[LW-1:0]),
    .a_less  (cmp_less)
  );

  // list element storage, LIST_DEPTH slots per list
  khm_ram #(
    .WIDTH (VW),
    .DEPTH (SDEPTH)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (store_waddr),
    .wdata (val_r),
    .raddr (store_raddr),
    .rdata (store_rdata)
  );

  // per-list read pointer and fill count
  khm_ram #(
    .WIDTH (MW),
    .DEPTH (LISTS)
  ) u_meta (
    .clk   (clk),
    .we    (meta_we),
    .waddr (lst_r),
    .wdata (meta_wdata),
    .raddr (lst_r),
    .rdata (meta_rdata)
  );

  // binary min-heap of list heads; writes always go to the hole
  khm_ram #(
    .WIDTH (EW),
    .DEPTH (LISTS)
  ) u_heap (
    .clk   (clk),
    .we    (heap_we),
    .waddr (pos_r),
    .wdata (heap_wdata),
    .raddr (heap_raddr),
    .rdata (heap_rdata)
  );

  assign in_chan.ready = (state_r == S_IDLE);
  assign out_load      = (state_r == S_DONE) && (!out_valid_r || out_chan.ready);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    merging_nxt    = merging_r;
    lvalid_nxt     = lvalid_r;
    lst_nxt        = lst_r;
    val_nxt        = val_r;
    ctx_pop_nxt    = ctx_pop_r;
    pos_nxt        = pos_r;
    bpos_nxt       = bpos_r;
    cur_nxt        = cur_r;
    best_nxt       = best_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;
    res_list_nxt   = res_list_r;
    meta_we        = 1'b0;
    meta_wdata     = {m_head, m_fill};
    store_we       = 1'b0;
    heap_we        = 1'b0;
    heap_wdata     = cur_r;
    heap_raddr     = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          lst_nxt        = LW'(in_chan.list_index);
          val_nxt        = in_chan.value;
          res_status_nxt = khm_pkg::ST_OK;
          res_value_nxt  = '0;
          res_list_nxt   = '0;
          unique case (in_chan.command)
            khm_pkg::CMD_LOAD: begin
              if (merging_r) begin
                res_status_nxt = khm_pkg::ST_PHASE;
                state_nxt      = S_DONE;
              end else if (int'(in_chan.list_index) >= LISTS) begin
                // list beyond the configured count behaves as full
                res_status_nxt = khm_pkg::ST_FULL;
                state_nxt      = S_DONE;
              end else begin
                state_nxt = S_LD_RD;
              end
            end
            khm_pkg::CMD_BEGIN: begin
              if (merging_r) begin
                res_status_nxt = khm_pkg::ST_PHASE;
                state_nxt      = S_DONE;
              end else begin
                lst_nxt     = '0;
                ctx_pop_nxt = 1'b0;
                state_nxt   = S_RF_RD;
              end
            end
            khm_pkg::CMD_POP: begin
              if (count_r == '0) begin
                res_status_nxt = khm_pkg::ST_EMPTY;
                state_nxt      = S_DONE;
              end else begin
                state_nxt = S_POP_RD;
              end
            end
            default: begin
              res_status_nxt = khm_pkg::ST_PHASE;
              state_nxt      = S_DONE;
            end
          endcase
        end
      end

      // ---- load: append to list -------------------------------------------
      S_LD_RD: begin
        state_nxt = S_LD_CHK;
      end
      S_LD_CHK: begin
        if (m_fill >= CW'(LIST_DEPTH)) begin
          res_status_nxt = khm_pkg::ST_FULL;
        end else begin
          store_we          = 1'b1;
          meta_we           = 1'b1;
          meta_wdata        = {m_head, m_fill + CW'(1)};
          lvalid_nxt[lst_r] = 1'b1;
        end
        state_nxt = S_DONE;
      end

      // ---- refill: next element of list lst_r into the heap ---------------
      S_RF_RD: begin
        state_nxt = S_RF_CHK;
      end
      S_RF_CHK: begin
        if (m_head < m_fill) begin
          meta_we           = 1'b1;
          meta_wdata        = {m_head + CW'(1), m_fill};
          lvalid_nxt[lst_r] = 1'b1;
          state_nxt         = S_RF_VAL;
        end else begin
          state_nxt = S_RF_NEXT;
        end
      end
      S_RF_VAL: begin
        cur_nxt   = {store_rdata, lst_r};
        pos_nxt   = LW'(count_r);
        count_nxt = count_r + CNTW'(1);
        state_nxt = S_UP_CHK;
      end
      S_UP_CHK: begin
        heap_raddr = par_w;
        if (pos_r == '0) begin
          heap_we   = 1'b1;
          state_nxt = S_RF_NEXT;
        end else begin
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        heap_we = 1'b1;
        if (cmp_less) begin
          // parent moves down into the hole
          heap_wdata = heap_rdata;
          pos_nxt    = par_w;
          state_nxt  = S_UP_CHK;
        end else begin
          state_nxt = S_RF_NEXT;
        end
      end
      S_RF_NEXT: begin
        if (ctx_pop_r) begin
          if (count_r == '0) begin
            // merge finished: lists cleared, back to loading
            merging_nxt = 1'b0;
            lvalid_nxt  = '0;
          end
          state_nxt = S_DONE;
        end else if (lst_r == LW'(LISTS - 1)) begin
          merging_nxt = (count_r != '0);
          state_nxt   = S_DONE;
        end else begin
          lst_nxt   = lst_r + LW'(1);
          state_nxt = S_RF_RD;
        end
      end

      // ---- pop: remove top, sift last entry down --------------------------
      S_POP_RD: begin
        state_nxt = S_POP_TOP;
      end
      S_POP_TOP: begin
        heap_raddr    = LW'(cnt_dec);
        res_value_nxt = hr_value;
        res_list_nxt  = khm_pkg::IDX_W'(hr_src);
        lst_nxt       = hr_src;
        ctx_pop_nxt   = 1'b1;
        count_nxt     = cnt_dec;
        state_nxt     = (cnt_dec == '0) ? S_RF_RD : S_POP_LAST;
      end
      S_POP_LAST: begin
        cur_nxt   = heap_rdata;
        pos_nxt   = '0;
        state_nxt = S_DN_L;
      end
      S_DN_L: begin
        heap_raddr = l_w[LW-1:0];
        if (l_w >= cnt_ext) begin
          heap_we   = 1'b1;
          state_nxt = S_RF_RD;
        end else begin
          state_nxt = S_DN_LC;
        end
      end
      S_DN_LC: begin
        heap_raddr = r_w[LW-1:0];
        best_nxt   = cmp_less ? heap_rdata : cur_r;
        bpos_nxt   = cmp_less ? l_w[LW-1:0] : pos_r;
        state_nxt  = (r_w < cnt_ext) ? S_DN_RC : S_DN_MV;
      end
      S_DN_RC: begin
        if (cmp_less) begin
          best_nxt = heap_rdata;
          bpos_nxt = r_w[LW-1:0];
        end
        state_nxt = S_DN_MV;
      end
      S_DN_MV: begin
        heap_we = 1'b1;
        if (bpos_r == pos_r) begin
          state_nxt = S_RF_RD;
        end else begin
          // smaller child moves up, hole follows it
          heap_wdata = best_r;
          pos_nxt    = bpos_r;
          state_nxt  = S_DN_L;
        end
      end

      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      merging_r   <= 1'b0;
      lvalid_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      merging_r <= merging_nxt;
      lvalid_r  <= lvalid_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    lst_r        <= lst_nxt;
    val_r        <= val_nxt;
    ctx_pop_r    <= ctx_pop_nxt;
    pos_r        <= pos_nxt;
    bpos_r       <= bpos_nxt;
    cur_r        <= cur_nxt;
    best_r       <= best_nxt;
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
    res_list_r   <= res_list_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_value_r  <= res_value_r;
      out_list_r   <= res_list_r;
      out_done_r   <= (count_r == '0);
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.status     = out_status_r;
  assign out_chan.out_value  = out_value_r;
  assign out_chan.out_list   = out_list_r;
  assign out_chan.merge_done = out_done_r;

endmodule

/* hw/rtl/khm_ram.sv */
// ----------------------------------------------------------------------------
// khm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module khm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/khm_cmp.sv */
// ----------------------------------------------------------------------------
// khm_cmp
// Heap key comparator: (value, source) pairs, signed value then lower source.
// ----------------------------------------------------------------------------
module khm_cmp #(
  parameter int SRC_W = 3
) (
  input  logic signed [khm_pkg::VALUE_W-1:0] a_value,
  input  logic        [SRC_W-1:0]            a_src,
  input  logic signed [khm_pkg::VALUE_W-1:0] b_value,
  input  logic        [SRC_W-1:0]            b_src,
  output logic                               a_less
);

  assign a_less = (a_value < b_value) || ((a_value == b_value) && (a_src < b_src));

endmodule
